// ===== hdl/cvdf_pkg.sv =====
package cvdf_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int MIN_SAMPLES  = 3;
    localparam int MIN_CLUSTER  = 3;

    localparam int IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int DIST_W    = 16;
    localparam int LIM_W     = 24;
    localparam int SIZE_W    = 6;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam int OUT_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_TOL_RATIO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTER_TOL_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESH_RATIO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESH_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_TOL_RATIO    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_TOL_BASE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_ALPHA   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_COUNT     = 3'd7;

    typedef enum logic [STAT_W-1:0] {
        STAT_WARMUP      = 3'd0,
        STAT_NO_CLUSTER  = 3'd1,
        STAT_INIT        = 3'd2,
        STAT_OK          = 3'd3,
        STAT_HOLD_JUMP   = 3'd4,
        STAT_ACCEPT_JUMP = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        T_IDLE, T_INS, T_SRCH, T_MUL, T_DEC, T_COPY, T_OUT
    } top_state_t;

    typedef enum logic [2:0] {
        S_IDLE, S_CRD, S_CLIM, S_CNT, S_RANK, S_EVAL, S_DONE
    } srch_state_t;

    typedef struct packed {
        logic              start;
        logic [FILL_W-1:0] fill;
        logic [IDX_W-1:0]  head;
        logic              stable_valid;
        logic [DIST_W-1:0] stable;
        logic [7:0]        tol_ratio;
        logic [DIST_W-1:0] tol_base;
    } srch_ctl_t;

    typedef struct packed {
        logic              done;
        logic [FILL_W-1:0] cnt;
        logic [DIST_W-1:0] center;
        logic [DIST_W-1:0] spread;
        logic [DIST_W-1:0] ctr;
        logic [LIM_W-1:0]  lim;
    } srch_res_t;

    function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] head,
                                                  input logic [FILL_W-1:0] idx);
        logic [FILL_W:0] s;
        s = (FILL_W+1)'(head) + (FILL_W+1)'(idx);
        if (s >= (FILL_W+1)'(WINDOW_DEPTH)) begin
            s = s - (FILL_W+1)'(WINDOW_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [DIST_W-1:0] absdiff(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // max(base*256, x*ratio)
    function automatic logic [LIM_W-1:0] lim_max(input logic [LIM_W-1:0] prod,
                                                 input logic [DIST_W-1:0] base);
        logic [LIM_W-1:0] b;
        b = {base, 8'h00};
        return (b > prod) ? b : prod;
    endfunction

    function automatic logic tol_ok(input logic [DIST_W-1:0] a,
                                    input logic [DIST_W-1:0] b,
                                    input logic [LIM_W-1:0] lim);
        return {absdiff(a, b), 8'h00} <= lim;
    endfunction

endpackage

// ===== hdl/cvdf_ram.sv =====
module cvdf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hdl/cvdf_search.sv =====
module cvdf_search import cvdf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  srch_ctl_t         ctl,
    input  logic [DIST_W-1:0] rd_a,
    input  logic [DIST_W-1:0] rd_b,
    output logic [IDX_W-1:0]  raddr_a,
    output logic [IDX_W-1:0]  raddr_b,
    output srch_res_t         res
);

    srch_state_t state_reg, state_next;

    logic [FILL_W-1:0] c_reg, j_reg, v_reg;
    logic              p_valid_reg, p_last_reg, p_final_reg;
    logic [DIST_W-1:0] ctr_reg;
    logic [LIM_W-1:0]  lim_reg;
    logic [FILL_W-1:0] cnt_reg, lt_reg, le_reg;
    logic [DIST_W-1:0] lo_reg, hi_reg, med_lo_reg, med_hi_reg;
    logic [FILL_W-1:0] win_cnt_reg;
    logic [DIST_W-1:0] win_center_reg, win_spread_reg, win_ctr_reg, best_ref_reg;
    logic [LIM_W-1:0]  win_lim_reg;
    logic              have_reg;

    logic [FILL_W-1:0] fill_m1, k, km1, lt_tot, le_tot;
    logic              issue, mem_a, mem_b;
    logic [DIST_W:0]   med_sum;
    logic [DIST_W-1:0] med, spread, ref_d;
    logic              take;

    assign fill_m1 = ctl.fill - FILL_W'(1);
    assign k       = cnt_reg >> 1;
    assign km1     = k - FILL_W'(1);
    assign mem_a   = tol_ok(rd_a, ctr_reg, lim_reg);
    assign mem_b   = tol_ok(rd_b, ctr_reg, lim_reg);
    assign lt_tot  = lt_reg + FILL_W'(mem_b && (rd_b < rd_a));
    assign le_tot  = le_reg + FILL_W'(mem_b && (rd_b <= rd_a));

    assign med_sum = (DIST_W+1)'(med_lo_reg) + (DIST_W+1)'(med_hi_reg);
    assign med     = cnt_reg[0] ? med_hi_reg : med_sum[DIST_W:1];
    assign spread  = hi_reg - lo_reg;
    assign ref_d   = ctl.stable_valid ? absdiff(med, ctl.stable) : '0;

    always_comb begin
        take = 1'b0;
        if (cnt_reg > win_cnt_reg) begin
            take = 1'b1;
        end else if (cnt_reg == win_cnt_reg) begin
            priority if (!have_reg) begin
                take = 1'b1;
            end else if (spread < win_spread_reg) begin
                take = 1'b1;
            end else if (spread == win_spread_reg && ref_d < best_ref_reg) begin
                take = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (ctl.start) state_next = S_CRD;
            S_CRD:  state_next = S_CLIM;
            S_CLIM: state_next = S_CNT;
            S_CNT:  if (p_valid_reg && p_last_reg) state_next = S_RANK;
            S_RANK: if (p_valid_reg && p_final_reg) state_next = S_EVAL;
            S_EVAL: state_next = (c_reg == fill_m1) ? S_DONE : S_CRD;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        issue   = 1'b0;
        raddr_a = phys_idx(ctl.head, j_reg);
        raddr_b = phys_idx(ctl.head, v_reg);
        unique case (state_reg)
            S_CRD:   raddr_a = phys_idx(ctl.head, c_reg);
            S_CNT:   issue = (v_reg < ctl.fill);
            S_RANK:  issue = (j_reg < ctl.fill);
            default: issue = 1'b0;
        endcase
        res.done   = (state_reg == S_DONE);
        res.cnt    = win_cnt_reg;
        res.center = win_center_reg;
        res.spread = win_spread_reg;
        res.ctr    = win_ctr_reg;
        res.lim    = win_lim_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            p_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        p_last_reg  <= (v_reg == fill_m1);
        p_final_reg <= (v_reg == fill_m1) && (j_reg == fill_m1);
        unique case (state_reg)
            S_IDLE: begin
                // winner stays readable after the sweep until the next start
                if (ctl.start) begin
                    c_reg       <= '0;
                    win_cnt_reg <= '0;
                    have_reg    <= 1'b0;
                end
            end
            S_CLIM: begin
                ctr_reg <= rd_a;
                lim_reg <= lim_max(LIM_W'(rd_a) * LIM_W'(ctl.tol_ratio), ctl.tol_base);
                v_reg   <= '0;
                cnt_reg <= '0;
                lo_reg  <= '1;
                hi_reg  <= '0;
            end
            S_CNT: begin
                if (issue) v_reg <= v_reg + FILL_W'(1);
                if (p_valid_reg && mem_b) begin
                    cnt_reg <= cnt_reg + FILL_W'(1);
                    if (rd_b < lo_reg) lo_reg <= rd_b;
                    if (rd_b > hi_reg) hi_reg <= rd_b;
                end
                if (p_valid_reg && p_last_reg) begin
                    j_reg  <= '0;
                    v_reg  <= '0;
                    lt_reg <= '0;
                    le_reg <= '0;
                end
            end
            S_RANK: begin
                if (issue) begin
                    if (v_reg == fill_m1) begin
                        v_reg <= '0;
                        j_reg <= j_reg + FILL_W'(1);
                    end else begin
                        v_reg <= v_reg + FILL_W'(1);
                    end
                end
                if (p_valid_reg) begin
                    if (p_last_reg) begin
                        lt_reg <= '0;
                        le_reg <= '0;
                        if (mem_a) begin
                            if (lt_tot <= k && k < le_tot) med_hi_reg <= rd_a;
                            if (lt_tot <= km1 && km1 < le_tot) med_lo_reg <= rd_a;
                        end
                    end else begin
                        lt_reg <= lt_tot;
                        le_reg <= le_tot;
                    end
                end
            end
            S_EVAL: begin
                c_reg <= c_reg + FILL_W'(1);
                if (take) begin
                    win_cnt_reg    <= cnt_reg;
                    win_center_reg <= med;
                    win_spread_reg <= spread;
                    win_ctr_reg    <= ctr_reg;
                    win_lim_reg    <= lim_reg;
                    best_ref_reg   <= ref_d;
                    have_reg       <= 1'b1;
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/cluster_vote_distance_filter_unit.sv =====
// Cluster-vote distance filter for ultrasonic range samples (1/16 cm units).
// Input channel s_*: one transaction per sample; s_tuser is the command
// (0 process sample, 1 clear all filter state), s_tdata the raw distance.
// Result channel m_*: exactly one result transaction per input transaction,
// m_tuser = status code, m_tdata = packed filter and cluster fields.
// Config channel cfg_*: register index + data, always ready; write only
// while the block is idle.
// A clear and a warmup sample skip the search. A full search sweeps every
// window entry as a center over the dual-read window RAM, and an accepted
// jump then rewrites the window with the cluster members.
// One item is in work at a time; s_tready is high only while idle.
// The result sits in an output register: a new sample is accepted while it
// waits, and a finished result holds until m_tready takes the old one.
// Reset (aresetn low, synchronous) clears the history, the stable value, the
// jump candidate and reloads default register values. Window RAM contents
// are not cleared; only entries below the fill count are ever read.
module cluster_vote_distance_filter_unit import cvdf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DIST_W-1:0]    s_tdata,   // [15:0] sample_distance
    input  logic                 s_tuser,   // [0] command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [0] output_valid, [16:1] output_distance, [17] cluster_valid,
    // [33:18] cluster_center, [39:34] cluster_size, [40] spread_valid,
    // [56:41] cluster_spread, [63:57] zero
    output logic [OUT_W-1:0]     m_tdata,
    output logic [STAT_W-1:0]    m_tuser,   // [2:0] status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    top_state_t state_reg, state_next;

    // configuration registers
    logic [7:0]        ctol_ratio_reg, jthr_ratio_reg, jtol_ratio_reg;
    logic [DIST_W-1:0] ctol_base_reg, jthr_min_reg, jtol_base_reg;
    logic [8:0]        alpha_reg;
    logic [3:0]        confirm_reg;

    // filter state
    logic [FILL_W-1:0] fill_reg;
    logic [IDX_W-1:0]  head_reg;
    logic              stable_valid_reg, cand_valid_reg;
    logic [DIST_W-1:0] stable_reg, cand_reg;
    logic [3:0]        hits_reg;

    // per-transaction working registers
    logic [DIST_W-1:0] sample_reg;
    status_t           res_status_reg;
    logic              res_cv_reg, res_sv_reg;
    logic [DIST_W-1:0] res_cc_reg, res_sp_reg;
    logic [SIZE_W-1:0] res_cs_reg;
    logic [LIM_W-1:0]  p_jump_reg, p_cand_reg;
    logic [LIM_W:0]    p_ema_a_reg, p_ema_b_reg;
    logic [FILL_W-1:0] cv_reg, w_reg;
    logic              cp_valid_reg, cp_last_reg;

    logic              m_valid_reg;
    logic [OUT_W-1:0]  m_data_reg;
    logic [STAT_W-1:0] m_user_reg;

    // RAM and search engine hookup
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr_a, srch_raddr_a, srch_raddr_b;
    logic [DIST_W-1:0] ram_wdata, rd_a, rd_b;
    srch_ctl_t         sctl;
    srch_res_t         sres;

    // insert and decision logic
    logic [FILL_W-1:0] nf;
    logic              full, accept, out_free, copy_issue, cp_member;
    logic [8:0]        alpha_eff;
    logic              near, cand_ok, confirm, go_copy;
    logic [3:0]        new_hits;
    logic [DIST_W-1:0] new_cand, ema;
    logic [LIM_W+1:0]  ema_sum;
    logic [DIST_W:0]   avg_sum;

    assign full       = (fill_reg == FILL_W'(WINDOW_DEPTH));
    assign nf         = full ? fill_reg : fill_reg + FILL_W'(1);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_valid_reg || m_tready;
    assign copy_issue = (state_reg == T_COPY) && (cv_reg < fill_reg);
    assign cp_member  = tol_ok(rd_a, sres.ctr, sres.lim);
    assign alpha_eff  = (alpha_reg > 9'd256) ? 9'd256 : alpha_reg;

    assign ema_sum = (LIM_W+2)'(p_ema_a_reg) + (LIM_W+2)'(p_ema_b_reg) + (LIM_W+2)'(128);
    assign ema     = ema_sum[DIST_W+7:8];
    assign avg_sum = (DIST_W+1)'(cand_reg) + (DIST_W+1)'(sres.center);

    // jump decision from the winning cluster
    always_comb begin
        near    = tol_ok(sres.center, stable_reg, lim_max(p_jump_reg, jthr_min_reg));
        cand_ok = tol_ok(sres.center, cand_reg, lim_max(p_cand_reg, jtol_base_reg));
        if (cand_ok) begin
            new_hits = (hits_reg == 4'd15) ? 4'd15 : hits_reg + 4'd1;
            new_cand = avg_sum[DIST_W:1];
        end else begin
            new_hits = 4'd1;
            new_cand = sres.center;
        end
        confirm = cand_valid_reg && (new_hits >= confirm_reg);
        go_copy = (int'(sres.cnt) >= MIN_CLUSTER) && stable_valid_reg && !near && confirm;
    end

    assign sctl.start        = (state_reg == T_INS) && (int'(nf) >= MIN_SAMPLES);
    assign sctl.fill         = fill_reg;
    assign sctl.head         = head_reg;
    assign sctl.stable_valid = stable_valid_reg;
    assign sctl.stable       = stable_reg;
    assign sctl.tol_ratio    = ctol_ratio_reg;
    assign sctl.tol_base     = ctol_base_reg;

    cvdf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (rd_a),
        .raddr_b (srch_raddr_b),
        .rdata_b (rd_b)
    );

    cvdf_search u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (sctl),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .raddr_a (srch_raddr_a),
        .raddr_b (srch_raddr_b),
        .res     (sres)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE: if (accept) state_next = s_tuser ? T_OUT : T_INS;
            T_INS:  state_next = (int'(nf) < MIN_SAMPLES) ? T_OUT : T_SRCH;
            T_SRCH: if (sres.done) state_next = T_MUL;
            T_MUL:  state_next = T_DEC;
            T_DEC:  state_next = go_copy ? T_COPY : T_OUT;
            T_COPY: if (cp_valid_reg && cp_last_reg) state_next = T_OUT;
            T_OUT:  if (out_free) state_next = T_IDLE;
            default: state_next = T_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        s_tready    = (state_reg == T_IDLE);
        ram_we      = 1'b0;
        ram_waddr   = phys_idx(head_reg, w_reg);
        ram_wdata   = rd_a;
        ram_raddr_a = phys_idx(head_reg, cv_reg);
        unique case (state_reg)
            T_INS: begin
                ram_we    = 1'b1;
                ram_waddr = full ? head_reg : phys_idx(head_reg, fill_reg);
                ram_wdata = sample_reg;
            end
            T_SRCH:  ram_raddr_a = srch_raddr_a;
            T_COPY:  ram_we = cp_valid_reg && cp_member;
            default: ram_we = 1'b0;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctol_ratio_reg <= 8'd13;
            ctol_base_reg  <= 16'd32;
            jthr_ratio_reg <= 8'd38;
            jthr_min_reg   <= 16'd160;
            jtol_ratio_reg <= 8'd26;
            jtol_base_reg  <= 16'd80;
            alpha_reg      <= 9'd77;
            confirm_reg    <= 4'd3;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CLUSTER_TOL_RATIO: ctol_ratio_reg <= cfg_data[7:0];
                REG_CLUSTER_TOL_BASE:  ctol_base_reg  <= cfg_data;
                REG_JUMP_THRESH_RATIO: jthr_ratio_reg <= cfg_data[7:0];
                REG_JUMP_THRESH_MIN:   jthr_min_reg   <= cfg_data;
                REG_JUMP_TOL_RATIO:    jtol_ratio_reg <= cfg_data[7:0];
                REG_JUMP_TOL_BASE:     jtol_base_reg  <= cfg_data;
                REG_SMOOTHING_ALPHA:   alpha_reg      <= cfg_data[8:0];
                REG_CONFIRM_COUNT:     confirm_reg    <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // control state and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= T_IDLE;
            fill_reg         <= '0;
            head_reg         <= '0;
            stable_valid_reg <= 1'b0;
            stable_reg       <= '0;
            cand_valid_reg   <= 1'b0;
            cand_reg         <= '0;
            hits_reg         <= '0;
            m_valid_reg      <= 1'b0;
            cp_valid_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cp_valid_reg <= copy_issue;

            if (state_reg == T_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                T_IDLE: begin
                    if (accept && s_tuser) begin
                        fill_reg         <= '0;
                        head_reg         <= '0;
                        stable_valid_reg <= 1'b0;
                        stable_reg       <= '0;
                        cand_valid_reg   <= 1'b0;
                        cand_reg         <= '0;
                        hits_reg         <= '0;
                    end
                end
                T_INS: begin
                    fill_reg <= nf;
                    if (full) head_reg <= phys_idx(head_reg, FILL_W'(1));
                end
                T_DEC: begin
                    if (int'(sres.cnt) < MIN_CLUSTER) begin
                        cand_valid_reg <= 1'b0;
                        cand_reg       <= '0;
                        hits_reg       <= '0;
                    end else if (!stable_valid_reg) begin
                        stable_valid_reg <= 1'b1;
                        stable_reg       <= sres.center;
                        cand_valid_reg   <= 1'b0;
                        cand_reg         <= '0;
                        hits_reg         <= '0;
                    end else if (near) begin
                        stable_reg     <= ema;
                        cand_valid_reg <= 1'b0;
                        cand_reg       <= '0;
                        hits_reg       <= '0;
                    end else if (!cand_valid_reg) begin
                        // first far cluster opens a candidate, never confirms
                        cand_valid_reg <= 1'b1;
                        cand_reg       <= sres.center;
                        hits_reg       <= 4'd1;
                    end else if (!confirm) begin
                        cand_reg <= new_cand;
                        hits_reg <= new_hits;
                    end else begin
                        stable_reg     <= new_cand;
                        cand_valid_reg <= 1'b0;
                        cand_reg       <= '0;
                        hits_reg       <= '0;
                    end
                end
                T_COPY: begin
                    if (cp_valid_reg && cp_last_reg) begin
                        fill_reg <= w_reg + FILL_W'(cp_member);
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cp_last_reg <= (cv_reg == fill_reg - FILL_W'(1));
        unique case (state_reg)
            T_IDLE: begin
                sample_reg     <= s_tdata;
                res_status_reg <= STAT_WARMUP;
                res_cv_reg     <= 1'b0;
                res_cc_reg     <= '0;
                res_cs_reg     <= '0;
                res_sv_reg     <= 1'b0;
                res_sp_reg     <= '0;
            end
            T_MUL: begin
                p_jump_reg  <= LIM_W'(stable_reg) * LIM_W'(jthr_ratio_reg);
                p_cand_reg  <= LIM_W'(cand_reg) * LIM_W'(jtol_ratio_reg);
                p_ema_a_reg <= (LIM_W+1)'(alpha_eff) * (LIM_W+1)'(sres.center);
                p_ema_b_reg <= (LIM_W+1)'(9'd256 - alpha_eff) * (LIM_W+1)'(stable_reg);
            end
            T_DEC: begin
                cv_reg     <= '0;
                w_reg      <= '0;
                res_cs_reg <= SIZE_W'(sres.cnt);
                res_sv_reg <= 1'b1;
                res_sp_reg <= sres.spread;
                if (int'(sres.cnt) < MIN_CLUSTER) begin
                    res_status_reg <= STAT_NO_CLUSTER;
                end else begin
                    res_cv_reg <= 1'b1;
                    res_cc_reg <= sres.center;
                    priority if (!stable_valid_reg) begin
                        res_status_reg <= STAT_INIT;
                    end else if (near) begin
                        res_status_reg <= STAT_OK;
                    end else if (confirm) begin
                        res_status_reg <= STAT_ACCEPT_JUMP;
                    end else begin
                        res_status_reg <= STAT_HOLD_JUMP;
                    end
                end
            end
            T_COPY: begin
                // compact winning members to the front of the window
                if (copy_issue) cv_reg <= cv_reg + FILL_W'(1);
                if (cp_valid_reg && cp_member) w_reg <= w_reg + FILL_W'(1);
            end
            T_OUT: begin
                if (out_free) begin
                    m_user_reg <= res_status_reg;
                    m_data_reg <= {7'b0, res_sp_reg, res_sv_reg, res_cs_reg,
                                   res_cc_reg, res_cv_reg, stable_reg, stable_valid_reg};
                end
            end
            default: ;
        endcase
    end

endmodule
